// File: rtl/core/bch_pkg.sv
// Shared types, constants and GF(64) arithmetic for the BCH(63,51) decoder.
`timescale 1ns / 1ps
`default_nettype none

package bch_pkg;

    localparam int WORD_W = 63;
    localparam int SYM_W  = 6;
    localparam int POS_W  = 6;

    localparam logic [SYM_W:0]   GF_POLY  = 7'h43;
    localparam logic [SYM_W-1:0] GF_ONE   = 6'h01;
    localparam logic [SYM_W-1:0] GF_ALPHA = 6'h02;
    localparam logic [SYM_W-1:0] GF_ALPHA3 = 6'h08;
    localparam logic [POS_W-1:0] LAST_X   = 6'd63;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYND,
        S_CHK,
        S_SQ,
        S_CUBE,
        S_INV,
        S_L2,
        S_CHIEN,
        S_LOG,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } synd_ctl_t;

    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b);
        logic [SYM_W:0]   x;
        logic [SYM_W-1:0] r;
        x = {1'b0, a};
        r = '0;
        for (int i = 0; i < SYM_W; i++)
        begin
            if (b[i])
            begin
                r = r ^ x[SYM_W-1:0];
            end
            x = x << 1;
            if (x[SYM_W])
            begin
                x = x ^ GF_POLY;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bch_63_51_two_error_decoder.sv
// Top level: two-error BCH(63,51) decoder with syndrome, locator and Chien sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command port: a beat of received_word is taken on a rising edge where
//   start is high and busy is low. busy stays high until the result is out.
//   Result port: done is high for exactly one cycle; corrected_word, status,
//   error_count and the two positions are valid in that cycle only. The
//   receiver cannot stall, so the result is simply presented and dropped.
// Sequence
//   Bit-serial syndrome accumulation (one code bit per cycle), then a
//   check state. Clean words and words with S1=0 finish there.
//   Otherwise: squaring and cubing S1 through the shared GF multiplier,
//   an inverse search stepping alpha powers, a Lambda2 step, then a
//   Chien pass testing x=1..63 one per cycle, pausing at each root for
//   a log search. One beat is in flight at a time: no new word is taken
//   until the sequencer is back in idle.
// Reset
//   rst_n asynchronously returns the sequencer to idle; no result pending.
// Syndromes of a binary word always satisfy S2=S1^2, S4=S2^2, so only S1
// and S3 are formed. Lambda = 1 + S1 x + ((S3+S1^3)/S1) x^2.

module bch_63_51_two_error_decoder (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [bch_pkg::WORD_W-1:0]   received_word,
    output logic                         done,
    output logic [bch_pkg::WORD_W-1:0]   corrected_word,
    output logic [1:0]                   status,
    output logic [1:0]                   error_count,
    output logic [bch_pkg::POS_W-1:0]    first_error_position,
    output logic [bch_pkg::POS_W-1:0]    second_error_position
);
    import bch_pkg::*;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] word_reg;
    logic [POS_W-1:0]  cnt_reg, cnt_next;     // syndrome bit count / search exponent
    logic [SYM_W-1:0]  t_reg, t_next;         // S1^2, then S3+S1^3
    logic [SYM_W-1:0]  p_reg, p_next;         // search value
    logic [SYM_W-1:0]  q_reg, q_next;         // alpha^j, gives inverse
    logic [SYM_W-1:0]  l2_reg, l2_next;
    logic [POS_W-1:0]  x_reg, x_next;         // Chien point
    logic [1:0]        rc_reg, rc_next;       // roots found
    logic [POS_W-1:0]  pos0_reg, pos0_next;
    logic [POS_W-1:0]  pos1_reg, pos1_next;
    status_t           st_reg, st_next;

    synd_ctl_t         sctl;
    logic [SYM_W-1:0]  s1, s3;

    logic [SYM_W-1:0]  ma, mb, mp;            // shared multiplier
    logic [SYM_W-1:0]  chien_y;
    logic [1:0]        dl;
    logic [1:0]        rc_inc;
    logic [WORD_W-1:0] flip;

    bch_synd u_synd (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (sctl),
        .word (received_word),
        .s1   (s1),
        .s3   (s3)
    );

    assign mp      = gf_mul(ma, mb);
    assign chien_y = GF_ONE ^ mp ^ gf_mul(l2_reg, gf_mul(x_reg, x_reg));
    assign dl      = (l2_reg != '0) ? 2'd2 : 2'd1;
    assign rc_inc  = rc_reg + 2'd1;

    always_comb
    begin
        unique case (state_reg)
            S_SQ:    begin ma = s1;    mb = s1;    end
            S_CUBE:  begin ma = t_reg; mb = s1;    end
            S_L2:    begin ma = t_reg; mb = q_reg; end
            default: begin ma = s1;    mb = x_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            word_reg <= received_word;
        end
        cnt_reg  <= cnt_next;
        t_reg    <= t_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        l2_reg   <= l2_next;
        x_reg    <= x_next;
        rc_reg   <= rc_next;
        pos0_reg <= pos0_next;
        pos1_reg <= pos1_next;
        st_reg   <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        l2_next    = l2_reg;
        x_next     = x_reg;
        rc_next    = rc_reg;
        pos0_next  = pos0_reg;
        pos1_next  = pos1_reg;
        st_next    = st_reg;
        sctl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sctl.load  = 1'b1;
                    cnt_next   = '0;
                    rc_next    = '0;
                    pos0_next  = '0;
                    pos1_next  = '0;
                    st_next    = ST_OK;
                    state_next = S_SYND;
                end
            end
            S_SYND:
            begin
                sctl.step = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == POS_W'(WORD_W - 1))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (s1 == '0)
                begin
                    // clean word, or a syndrome no two-error pattern gives
                    st_next    = (s3 != '0) ? ST_FAIL : ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                t_next     = mp;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                t_next     = mp ^ s3;
                p_next     = s1;
                q_next     = GF_ONE;
                state_next = S_INV;
            end
            S_INV:
            begin
                if (p_reg == GF_ONE)
                begin
                    state_next = S_L2;
                end
                else
                begin
                    p_next = gf_mul(p_reg, GF_ALPHA);
                    q_next = gf_mul(q_reg, GF_ALPHA);
                end
            end
            S_L2:
            begin
                l2_next    = mp;
                x_next     = POS_W'(1);
                state_next = S_CHIEN;
            end
            S_CHIEN:
            begin
                if (chien_y == '0)
                begin
                    // log(1/x): smallest j with alpha^j * x == 1
                    p_next     = x_reg;
                    cnt_next   = '0;
                    state_next = S_LOG;
                end
                else if (x_reg == LAST_X)
                begin
                    st_next    = ST_FEW;
                    state_next = S_DONE;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            S_LOG:
            begin
                if (p_reg == GF_ONE)
                begin
                    if (rc_reg == 2'd0)
                    begin
                        pos0_next = cnt_reg;
                    end
                    else
                    begin
                        pos1_next = cnt_reg;
                    end
                    rc_next = rc_inc;
                    if (rc_inc >= dl)
                    begin
                        state_next = S_DONE;
                    end
                    else if (x_reg == LAST_X)
                    begin
                        st_next    = ST_FEW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        x_next     = x_reg + 1'b1;
                        state_next = S_CHIEN;
                    end
                end
                else
                begin
                    p_next   = gf_mul(p_reg, GF_ALPHA);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        flip = '0;
        if (rc_reg >= 2'd1)
        begin
            flip = flip | (WORD_W'(1) << pos0_reg);
        end
        if (rc_reg >= 2'd2)
        begin
            flip = flip | (WORD_W'(1) << pos1_reg);
        end
    end

    assign busy                  = (state_reg != S_IDLE);
    assign done                  = (state_reg == S_DONE);
    assign status                = st_reg;
    assign corrected_word        = (st_reg == ST_OK) ? (word_reg ^ flip) : word_reg;
    assign error_count           = (st_reg == ST_OK) ? rc_reg : 2'd0;
    assign first_error_position  = pos0_reg;
    assign second_error_position = pos1_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command beat taken but not busy");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FAIL) |-> (error_count == 2'd0) &&
            (first_error_position == '0) && (corrected_word == word_reg))
        else $error("failed word altered");

    a_roots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rc_reg != 2'd3)
        else $error("more than two roots recorded");

endmodule

`default_nettype wire

// File: rtl/core/bch_synd.sv
// Bit-serial syndrome accumulator: S1 and S3 by Horner's rule, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module bch_synd (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire  bch_pkg::synd_ctl_t       ctl,
    input  wire  [bch_pkg::WORD_W-1:0]     word,
    output logic [bch_pkg::SYM_W-1:0]      s1,
    output logic [bch_pkg::SYM_W-1:0]      s3
);
    import bch_pkg::*;

    logic [WORD_W-1:0] sh_reg;
    logic [SYM_W-1:0]  s1_reg, s3_reg;
    logic [SYM_W-1:0]  s1_next, s3_next;

    always_comb
    begin
        s1_next = gf_mul(s1_reg, GF_ALPHA)  ^ {{(SYM_W-1){1'b0}}, sh_reg[WORD_W-1]};
        s3_next = gf_mul(s3_reg, GF_ALPHA3) ^ {{(SYM_W-1){1'b0}}, sh_reg[WORD_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sh_reg <= word;
            s1_reg <= '0;
            s3_reg <= '0;
        end
        else if (ctl.step)
        begin
            sh_reg <= sh_reg << 1;
            s1_reg <= s1_next;
            s3_reg <= s3_next;
        end
    end

    assign s1 = s1_reg;
    assign s3 = s3_reg;

    // load and step never coincide
    a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.step))
        else $error("syndrome load and step together");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (s1_reg == '0) && (s3_reg == '0))
        else $error("syndromes not cleared on load");

    a_step_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |=> sh_reg[0] == 1'b0)
        else $error("word not shifted");

endmodule

`default_nettype wire
